@@ sv/jdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_pkg: shared types and constants for the JVM descriptor checker
// Parse phases, type contexts, character codes and small phase helpers.
// ----------------------------------------------------------------------------
package jdc_pkg;

    typedef enum logic [9:0] {
        PH_START     = 10'b00_0000_0001,
        PH_ARR_FIELD = 10'b00_0000_0010,
        PH_CLS_FIELD = 10'b00_0000_0100,
        PH_PARAM     = 10'b00_0000_1000,
        PH_ARR_PARAM = 10'b00_0001_0000,
        PH_CLS_PARAM = 10'b00_0010_0000,
        PH_RET       = 10'b00_0100_0000,
        PH_ARR_RET   = 10'b00_1000_0000,
        PH_CLS_RET   = 10'b01_0000_0000,
        PH_DONE      = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        CTX_FIELD = 2'd0,
        CTX_PARAM = 2'd1,
        CTX_RET   = 2'd2
    } ctx_t;

    typedef struct packed {
        logic       descriptor_valid;
        logic [7:0] arg_slots;
    } result_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_HIGH   = 8'h7F;
    localparam logic [7:0] SLOT_MAX  = 8'hFF;

    function automatic phase_t arr_phase(input ctx_t ctx);
        phase_t ph;
        case (ctx)
            CTX_PARAM: ph = PH_ARR_PARAM;
            CTX_RET:   ph = PH_ARR_RET;
            default:   ph = PH_ARR_FIELD;
        endcase
        return ph;
    endfunction

    function automatic phase_t cls_phase(input ctx_t ctx);
        phase_t ph;
        case (ctx)
            CTX_PARAM: ph = PH_CLS_PARAM;
            CTX_RET:   ph = PH_CLS_RET;
            default:   ph = PH_CLS_FIELD;
        endcase
        return ph;
    endfunction

    // A completed parameter returns to the parameter list; anything else ends it.
    function automatic phase_t done_phase(input ctx_t ctx);
        return (ctx == CTX_PARAM) ? PH_PARAM : PH_DONE;
    endfunction

    function automatic logic is_primitive(input logic [7:0] b, input logic float_en);
        return (b == CH_B) || (b == CH_C) || (b == CH_I) || (b == CH_J) ||
               (b == CH_S) || (b == CH_Z) ||
               (float_en && ((b == CH_F) || (b == CH_D)));
    endfunction

endpackage
`default_nettype wire

@@ sv/jdc_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_parser: descriptor grammar state and its per-byte update
// Holds the parse state, advancing it a byte per step; a last byte resets it.
// ----------------------------------------------------------------------------
module jdc_parser #(
    parameter int MAX_ARRAY_DIMS = 255
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last_byte,
    input  wire logic            method_mode,
    input  wire logic            float_en,
    output jdc_pkg::result_t     result
);

    localparam int DEPTH_W = $clog2(MAX_ARRAY_DIMS + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_ARRAY_DIMS);

    jdc_pkg::phase_t     phase_reg, phase_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [7:0]          slots_reg, slots_next;
    logic                failed_reg, failed_next;
    logic                seg_empty_reg, seg_empty_next;

    logic                do_type;
    logic                do_class;
    jdc_pkg::ctx_t       ctx;
    logic [8:0]          slot_sum;
    logic                letter;
    logic                digit;
    logic                valid_now;

    assign letter = ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) ||
                    ((data_byte >= 8'h41) && (data_byte <= 8'h5A));
    assign digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);

    // Long, and double when floats are on, take two slots.
    assign slot_sum = {1'b0, slots_reg} +
                      (((data_byte == jdc_pkg::CH_J) ||
                        (float_en && (data_byte == jdc_pkg::CH_D))) ? 9'd2 : 9'd1);

    always_comb
    begin
        phase_next     = phase_reg;
        depth_next     = depth_reg;
        slots_next     = slots_reg;
        failed_next    = failed_reg;
        seg_empty_next = seg_empty_reg;
        do_type        = 1'b0;
        do_class       = 1'b0;
        ctx            = jdc_pkg::CTX_FIELD;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                jdc_pkg::PH_START:
                begin
                    if (method_mode)
                    begin
                        if (data_byte == jdc_pkg::CH_LPAREN)
                            phase_next = jdc_pkg::PH_PARAM;
                        else
                            failed_next = 1'b1;
                    end
                    else
                    begin
                        do_type = 1'b1;
                    end
                end
                jdc_pkg::PH_PARAM:
                begin
                    if (data_byte == jdc_pkg::CH_RPAREN)
                        phase_next = jdc_pkg::PH_RET;
                    else
                    begin
                        slots_next = slot_sum[8] ? jdc_pkg::SLOT_MAX : slot_sum[7:0];
                        do_type    = 1'b1;
                        ctx        = jdc_pkg::CTX_PARAM;
                    end
                end
                jdc_pkg::PH_RET:
                begin
                    if (data_byte == jdc_pkg::CH_V)
                        phase_next = jdc_pkg::PH_DONE;
                    else
                    begin
                        do_type = 1'b1;
                        ctx     = jdc_pkg::CTX_RET;
                    end
                end
                jdc_pkg::PH_ARR_FIELD: do_type = 1'b1;
                jdc_pkg::PH_ARR_PARAM:
                begin
                    do_type = 1'b1;
                    ctx     = jdc_pkg::CTX_PARAM;
                end
                jdc_pkg::PH_ARR_RET:
                begin
                    do_type = 1'b1;
                    ctx     = jdc_pkg::CTX_RET;
                end
                jdc_pkg::PH_CLS_FIELD: do_class = 1'b1;
                jdc_pkg::PH_CLS_PARAM:
                begin
                    do_class = 1'b1;
                    ctx      = jdc_pkg::CTX_PARAM;
                end
                jdc_pkg::PH_CLS_RET:
                begin
                    do_class = 1'b1;
                    ctx      = jdc_pkg::CTX_RET;
                end
                default: failed_next = 1'b1;
            endcase
        end

        if (do_type)
        begin
            if (data_byte == jdc_pkg::CH_LBRACK)
            begin
                if (depth_reg >= DEPTH_MAX)
                    failed_next = 1'b1;
                else
                begin
                    depth_next = depth_reg + 1'b1;
                    phase_next = jdc_pkg::arr_phase(ctx);
                end
            end
            else if (data_byte == jdc_pkg::CH_L)
            begin
                seg_empty_next = 1'b1;
                phase_next     = jdc_pkg::cls_phase(ctx);
            end
            else if (jdc_pkg::is_primitive(data_byte, float_en))
            begin
                depth_next = '0;
                phase_next = jdc_pkg::done_phase(ctx);
            end
            else
                failed_next = 1'b1;
        end

        if (do_class)
        begin
            if (data_byte == jdc_pkg::CH_SEMI)
            begin
                if (seg_empty_reg)
                    failed_next = 1'b1;
                else
                begin
                    depth_next = '0;
                    phase_next = jdc_pkg::done_phase(ctx);
                end
            end
            else if (data_byte == jdc_pkg::CH_SLASH)
            begin
                if (seg_empty_reg)
                    failed_next = 1'b1;
                else
                    seg_empty_next = 1'b1;
            end
            else if (digit)
            begin
                if (seg_empty_reg)
                    failed_next = 1'b1;
            end
            else if (letter || (data_byte == jdc_pkg::CH_USCORE) ||
                     (data_byte == jdc_pkg::CH_DOLLAR) || (data_byte >= jdc_pkg::CH_HIGH))
                seg_empty_next = 1'b0;
            else
                failed_next = 1'b1;
        end
    end

    assign valid_now               = !failed_next && (phase_next == jdc_pkg::PH_DONE);
    assign result.descriptor_valid = valid_now;
    assign result.arg_slots        = valid_now ? slots_next : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jdc_pkg::PH_START;
            depth_reg     <= '0;
            slots_reg     <= '0;
            failed_reg    <= 1'b0;
            seg_empty_reg <= 1'b1;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg     <= jdc_pkg::PH_START;
                depth_reg     <= '0;
                slots_reg     <= '0;
                failed_reg    <= 1'b0;
                seg_empty_reg <= 1'b1;
            end
            else
            begin
                phase_reg     <= phase_next;
                depth_reg     <= depth_next;
                slots_reg     <= slots_next;
                failed_reg    <= failed_next;
                seg_empty_reg <= seg_empty_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/jvm_descriptor_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jvm_descriptor_checker: streaming JVM field and method descriptor checker
// Takes one descriptor byte per item and reports validity and slot count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tdata = data_byte, tlast = last_byte, tuser = method_mode
//  m_*       out        tdata = descriptor_valid, arg_slots (one item per descriptor)
//  cfg_*     in         cfg_data = float_types_enabled
//
// One byte per cycle is sustained while no last byte waits for the result
// register. A byte is held in the input register, is parsed by the grammar
// logic, and a last byte loads its result into the result register for m_*.
// A last byte waits in the input register only while an earlier result is
// still held in the result register. Reset clears the parse state, empties
// both registers and sets float_types_enabled to one.
// ----------------------------------------------------------------------------
module jvm_descriptor_checker #(
    parameter int MAX_ARRAY_DIMS = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] method_mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] descriptor_valid, [8:1] arg_slots
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data   // [0] float_types_enabled
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              in_mode_reg;
    logic              step;
    logic              float_en_reg;
    logic              out_valid_reg;
    jdc_pkg::result_t  out_result_reg;
    jdc_pkg::result_t  result;
    logic              out_load;

    // Only a last byte needs room in the result register.
    assign step      = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign out_load  = step && in_last_reg;
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    jdc_parser #(
        .MAX_ARRAY_DIMS (MAX_ARRAY_DIMS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .method_mode (in_mode_reg),
        .float_en    (float_en_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            float_en_reg  <= 1'b1;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
                float_en_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_mode_reg <= s_tuser;
        end
        if (out_load)
            out_result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg.arg_slots, out_result_reg.descriptor_valid};

endmodule
`default_nettype wire
